FILE: hw/rtl/eucjp_pkg.sv
// ----------------------------------------------------------------------------
// EUC-JP rewriter package
// Shared types, code points and the two-byte rewrite table.
// ----------------------------------------------------------------------------
package eucjp_pkg;

   // Lead byte of a three-byte (SS3) character
   localparam logic [7:0] SS3_LEAD    = 8'h8f;

   // Rows of the two-byte table that hold rewritable characters
   localparam logic [7:0] ROW_SYMBOL  = 8'ha1;
   localparam logic [7:0] ROW_ALNUM   = 8'ha3;

   // Symbol row cells
   localparam logic [7:0] CELL_MINUS  = 8'hdd;
   localparam logic [7:0] CELL_LPAREN = 8'hca;
   localparam logic [7:0] CELL_RPAREN = 8'hcb;

   // Alphanumeric row ranges
   localparam logic [7:0] DIGIT_FIRST = 8'hb0;
   localparam logic [7:0] DIGIT_LAST  = 8'hb9;
   localparam logic [7:0] UPPER_FIRST = 8'hc1;
   localparam logic [7:0] UPPER_LAST  = 8'hda;
   localparam logic [7:0] LOWER_FIRST = 8'he1;
   localparam logic [7:0] LOWER_LAST  = 8'hfa;

   // ASCII targets
   localparam logic [7:0] ASCII_MINUS  = 8'h2d;
   localparam logic [7:0] ASCII_LPAREN = 8'h28;
   localparam logic [7:0] ASCII_RPAREN = 8'h29;
   localparam logic [7:0] ASCII_ZERO   = 8'h30;
   localparam logic [7:0] ASCII_UPPER  = 8'h41;
   localparam logic [7:0] ASCII_LOWER  = 8'h61;

   // Result status codes
   localparam logic STATUS_DATA    = 1'b0;
   localparam logic STATUS_ILLEGAL = 1'b1;

   // One framed character waiting for output: up to three bytes
   typedef struct packed {
      logic [2:0][7:0] bytes;     // bytes[0] goes out first
      logic [1:0]      last_idx;  // index of the final byte
      logic            illegal;   // illegal-sequence marker
   } job_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // ASCII replacement of a two-byte code, zero when there is none
   function automatic logic [7:0] narrow(input logic [7:0] lead, input logic [7:0] trail);
      logic [7:0] res;
      res = 8'h00;
      if (lead == ROW_SYMBOL) begin
         if (trail == CELL_MINUS)       res = ASCII_MINUS;
         else if (trail == CELL_LPAREN) res = ASCII_LPAREN;
         else if (trail == CELL_RPAREN) res = ASCII_RPAREN;
      end else if (lead == ROW_ALNUM) begin
         if (trail >= DIGIT_FIRST && trail <= DIGIT_LAST)
            res = 8'(trail - DIGIT_FIRST + ASCII_ZERO);
         else if (trail >= UPPER_FIRST && trail <= UPPER_LAST)
            res = 8'(trail - UPPER_FIRST + ASCII_UPPER);
         else if (trail >= LOWER_FIRST && trail <= LOWER_LAST)
            res = 8'(trail - LOWER_FIRST + ASCII_LOWER);
      end
      return res;
   endfunction

endpackage

FILE: hw/rtl/eucjp_if.sv
// ----------------------------------------------------------------------------
// EUC-JP rewriter channels
// Valid/ready channels for input bytes and result bytes.
// ----------------------------------------------------------------------------
interface eucjp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       stream_end;

   modport source (output valid, output data_byte, output stream_end, input ready);
   modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface eucjp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       status;
   logic       run_last;

   modport source (output valid, output out_byte, output status, output run_last,
                   input ready);
   modport sink   (input valid, input out_byte, input status, input run_last,
                   output ready);
endinterface

FILE: hw/rtl/eucjp_fullwidth_to_ascii_unit.sv
// ----------------------------------------------------------------------------
// EUC-JP full-width to ASCII unit
// Frames an EUC-JP byte stream and rewrites full-width minus, parentheses,
// digits and Latin letters as single ASCII bytes.
//
//   channel   dir  payload                          handshake
//   req_ch    in   data_byte[7:0], stream_end        valid / ready
//   rsp_ch    out  out_byte[7:0], status, run_last   valid / ready
//
// One input byte is taken per cycle while the job queue has room; each
// finished character leaves as one to three result bytes, one per cycle
// while the receiver is ready, from the output register, which a closing
// byte's job reaches through the queue. The queue (QUEUE_DEPTH jobs)
// lets input continue while results stall. Reset is synchronous and
// clears framing, the halt flag, queue pointers and output valid.
// ----------------------------------------------------------------------------
module eucjp_fullwidth_to_ascii_unit import eucjp_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   eucjp_req_if.sink   req_ch,
   eucjp_rsp_if.source rsp_ch
);

   queue_status_type q_status;
   job_type          push_job;
   job_type          head_job;
   logic             push;
   logic             pop;

   // Frame input bytes
   eucjp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   // Buffer framed characters
   eucjp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   // Emit result bytes
   eucjp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .q_status (q_status),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

FILE: hw/rtl/eucjp_front.sv
// ----------------------------------------------------------------------------
// EUC-JP rewriter front end
// Frames input bytes into characters and pushes one job per finished
// character (or one illegal-sequence job) into the queue.
// ----------------------------------------------------------------------------
module eucjp_front import eucjp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   eucjp_req_if.sink        req_ch,
   input  queue_status_type q_status,
   output logic             push,
   output job_type          push_job
);

   logic [1:0] pending_ff, pending_in;
   logic [7:0] lead_ff, lead_in;
   logic [7:0] second_ff, second_in;
   logic       halted_ff, halted_in;
   logic       take;
   logic [7:0] b;
   logic [7:0] c;

   assign req_ch.ready = !q_status.full;
   assign take         = req_ch.valid && req_ch.ready;
   assign b            = req_ch.data_byte;
   assign c            = narrow(lead_ff, b);

   // Frame the byte and build the job
   always_comb begin
      pending_in = pending_ff;
      lead_in    = lead_ff;
      second_in  = second_ff;
      halted_in  = halted_ff;
      push       = 1'b0;
      push_job   = '0;
      if (take && !halted_ff) begin
         if (req_ch.stream_end) begin
            if (pending_ff != 2'd0) begin
               push             = 1'b1;
               push_job.illegal = 1'b1;
               pending_in       = 2'd0;
               lead_in          = 8'h00;
               second_in        = 8'h00;
               halted_in        = 1'b1;
            end
         end else if (pending_ff == 2'd0) begin
            if (b[7]) begin
               lead_in    = b;
               pending_in = 2'd1;
            end else if (b != 8'h00) begin
               push              = 1'b1;
               push_job.bytes[0] = b;
            end
         end else if (!b[7]) begin
            // Trailing byte without high bit: drop the character and halt
            push             = 1'b1;
            push_job.illegal = 1'b1;
            pending_in       = 2'd0;
            lead_in          = 8'h00;
            second_in        = 8'h00;
            halted_in        = 1'b1;
         end else if (lead_ff == SS3_LEAD && pending_ff == 2'd1) begin
            second_in  = b;
            pending_in = 2'd2;
         end else begin
            push       = 1'b1;
            pending_in = 2'd0;
            lead_in    = 8'h00;
            second_in  = 8'h00;
            if (lead_ff == SS3_LEAD) begin
               push_job.bytes    = {b, second_ff, lead_ff};
               push_job.last_idx = 2'd2;
            end else if (c != 8'h00) begin
               push_job.bytes[0] = c;
            end else begin
               push_job.bytes[0] = lead_ff;
               push_job.bytes[1] = b;
               push_job.last_idx = 2'd1;
            end
         end
      end
   end

   // Hold framing state
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         lead_ff    <= 8'h00;
         second_ff  <= 8'h00;
         halted_ff  <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         lead_ff    <= lead_in;
         second_ff  <= second_in;
         halted_ff  <= halted_in;
      end
   end

`ifndef ASSERT_OFF
   a_illegal_halts: assert property (@(posedge clock) disable iff (reset)
      (push && push_job.illegal) |=> halted_ff)
      else $error("illegal job without halt");
   a_halted_quiet: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> (!push && pending_ff == 2'd0))
      else $error("activity while halted");
   a_second_only_ss3: assert property (@(posedge clock) disable iff (reset)
      (pending_ff == 2'd2) |-> (lead_ff == SS3_LEAD))
      else $error("second byte held for non-SS3 lead");
`endif

endmodule

FILE: hw/rtl/eucjp_queue.sv
// ----------------------------------------------------------------------------
// EUC-JP rewriter job queue
// Short FIFO of framed characters between the front and back ends.
// ----------------------------------------------------------------------------
module eucjp_queue import eucjp_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_job       = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed job
   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= push_job;
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> !pop)
      else $error("pop from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");
`endif

endmodule

FILE: hw/rtl/eucjp_back.sv
// ----------------------------------------------------------------------------
// EUC-JP rewriter back end
// Unrolls each queued job into result bytes through an output register.
// ----------------------------------------------------------------------------
module eucjp_back import eucjp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  job_type          head_job,
   input  queue_status_type q_status,
   output logic             pop,
   eucjp_rsp_if.source      rsp_ch
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       status_ff, status_in;
   logic       last_ff, last_in;
   logic       load;
   logic       at_last;

   assign load    = !q_status.empty && (!valid_ff || rsp_ch.ready);
   assign at_last = (idx_ff == head_job.last_idx);
   assign pop     = load && at_last;

   // Pick the byte at the current index
   always_comb begin
      case (idx_ff)
         2'd0:    byte_in = head_job.bytes[0];
         2'd1:    byte_in = head_job.bytes[1];
         2'd2:    byte_in = head_job.bytes[2];
         default: byte_in = 8'h00;
      endcase
      status_in = head_job.illegal ? STATUS_ILLEGAL : STATUS_DATA;
      last_in   = at_last;
      idx_in    = idx_ff;
      if (load)
         idx_in = at_last ? 2'd0 : idx_ff + 2'd1;
      if (load)
         valid_in = 1'b1;
      else if (rsp_ch.ready)
         valid_in = 1'b0;
      else
         valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Load output payload
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= byte_in;
         status_ff <= status_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_ch.valid    = valid_ff;
   assign rsp_ch.out_byte = byte_ff;
   assign rsp_ch.status   = status_ff;
   assign rsp_ch.run_last = last_ff;

`ifndef ASSERT_OFF
   a_illegal_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && status_ff == STATUS_ILLEGAL) |-> last_ff)
      else $error("illegal result not marked last");
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> (idx_ff <= head_job.last_idx))
      else $error("byte index past end of job");
   a_idx_rewinds: assert property (@(posedge clock) disable iff (reset)
      pop |=> (idx_ff == 2'd0))
      else $error("index not rewound after pop");
`endif

endmodule

FILE: sim/tb_eucjp_fullwidth_to_ascii_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// EUC-JP full-width to ASCII unit testbench
// Feeds a byte stream through the request channel, predicts result bytes
// with a behavioral rewriter or the directed table, checks the result channel
// in order. Directed table first, then random well-formed characters with
// noise, then one malformed character that halts the stream for good.
// ----------------------------------------------------------------------------
module tb_eucjp_fullwidth_to_ascii_unit;
   import eucjp_pkg::*;

   localparam int RANDOM_ITEMS = 300;
   localparam int STALL_CYCLES = 120;
   localparam int DRAIN_CYCLES = 20;
   localparam int UNTYPED      = -1;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       status;
      logic       run_last;
   } result_t;

   typedef struct packed {
      logic [7:0]      data_in;
      logic            end_in;
      logic            typed;
      logic [1:0]      count;
      logic [2:0][7:0] bytes;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset;

   eucjp_req_if req_ch ();
   eucjp_rsp_if rsp_ch ();

   eucjp_fullwidth_to_ascii_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Rewriter state
   logic [1:0] frame_count;
   logic [7:0] frame_lead;
   logic [7:0] frame_second;
   logic       stream_halted;

   result_t   expected_bytes [$];
   stim_row_t dir_rows [$];
   int        mismatch_count = 0;
   int        items_sent     = 0;
   int        req_idle_pct   = 35;
   int        rsp_idle_pct   = 35;
   logic      stall_request  = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ASCII replacement of a full-width two-byte code, zero when there is none
   function automatic logic [7:0] ascii_of(input logic [7:0] lead, input logic [7:0] trail);
      logic [7:0] a;
      a = 8'h00;
      if (lead == ROW_SYMBOL) begin
         case (trail)
            CELL_MINUS:  a = ASCII_MINUS;
            CELL_LPAREN: a = ASCII_LPAREN;
            CELL_RPAREN: a = ASCII_RPAREN;
            default:     a = 8'h00;
         endcase
      end else if (lead == ROW_ALNUM) begin
         if (trail inside {[DIGIT_FIRST:DIGIT_LAST]}) a = ASCII_ZERO + (trail - DIGIT_FIRST);
         else if (trail inside {[UPPER_FIRST:UPPER_LAST]}) a = ASCII_UPPER + (trail - UPPER_FIRST);
         else if (trail inside {[LOWER_FIRST:LOWER_LAST]}) a = ASCII_LOWER + (trail - LOWER_FIRST);
      end
      return a;
   endfunction

   // Advance the rewriter by one input byte and return the bytes it emits
   task automatic rewrite_step(input logic [7:0] b, input logic eos, output int n,
                               output logic [2:0][7:0] outs, output logic ill);
      logic [7:0] a;
      n    = 0;
      outs = '0;
      ill  = 1'b0;
      if (stream_halted) begin
         // drop everything until reset
      end else if (eos) begin
         if (frame_count != 0) begin
            ill = 1'b1;
            n   = 1;
         end
      end else if (frame_count == 0) begin
         if (b[7]) begin
            frame_lead  = b;
            frame_count = 2'd1;
         end else if (b != 8'h00) begin
            outs[0] = b;
            n       = 1;
         end
      end else if (!b[7]) begin
         ill = 1'b1;
         n   = 1;
      end else if (frame_lead == SS3_LEAD && frame_count == 2'd1) begin
         frame_second = b;
         frame_count  = 2'd2;
      end else begin
         if (frame_lead == SS3_LEAD) begin
            outs = {b, frame_second, frame_lead};
            n    = 3;
         end else begin
            a = ascii_of(frame_lead, b);
            if (a != 8'h00) begin
               outs[0] = a;
               n       = 1;
            end else begin
               outs[0] = frame_lead;
               outs[1] = b;
               n       = 2;
            end
         end
         frame_count  = 2'd0;
         frame_lead   = 8'h00;
         frame_second = 8'h00;
      end
      if (ill) begin
         frame_count   = 2'd0;
         frame_lead    = 8'h00;
         frame_second  = 8'h00;
         stream_halted = 1'b1;
      end
   endtask

   // Offer one item, wait for its acceptance and queue the results it causes
   task automatic offer_byte(input logic [7:0] b, input logic eos, input logic typed,
                             input logic [1:0] count, input logic [2:0][7:0] bytes);
      int              n;
      logic [2:0][7:0] outs;
      logic            ill;
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.data_byte  <= b;
      req_ch.stream_end <= eos;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      rewrite_step(b, eos, n, outs, ill);
      if (typed) begin
         n    = count;
         outs = bytes;
         ill  = 1'b0;
      end
      for (int k = 0; k < n; k++)
         expected_bytes.push_back({outs[k], ill ? STATUS_ILLEGAL : STATUS_DATA, k == n - 1});
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic eos);
      offer_byte(b, eos, 1'b0, 2'd0, '0);
   endtask

   task automatic add_row(input logic [7:0] b, input logic eos, input int n,
                          input logic [7:0] t0, input logic [7:0] t1, input logic [7:0] t2);
      dir_rows.push_back({b, eos, n != UNTYPED, 2'(n), t2, t1, t0});
   endtask

   // One well-formed character with random content, or a bit of noise
   task automatic send_random_char();
      int         kind;
      int         trails;
      logic [7:0] lead;
      logic [7:0] trail;
      kind   = $urandom_range(99);
      trails = 1;
      trail  = 8'($urandom_range(255, 128));
      if (kind < 35) begin
         // single byte, zero now and then
         send_byte(8'($urandom_range(127)), 1'b0);
         return;
      end else if (kind < 40) begin
         send_byte(8'($urandom_range(255)), 1'b1);
         return;
      end else if (kind < 70) begin
         if ($urandom_range(3) == 0) begin
            lead = ROW_SYMBOL;
            case ($urandom_range(3))
               0: trail = CELL_MINUS;
               1: trail = CELL_LPAREN;
               2: trail = CELL_RPAREN;
               default: ;
            endcase
         end else begin
            lead = ROW_ALNUM;
            case ($urandom_range(3))
               0: trail = 8'($urandom_range(DIGIT_LAST, DIGIT_FIRST));
               1: trail = 8'($urandom_range(UPPER_LAST, UPPER_FIRST));
               2: trail = 8'($urandom_range(LOWER_LAST, LOWER_FIRST));
               default: ;
            endcase
         end
      end else if (kind < 88) begin
         lead = 8'($urandom_range(255, 128));
      end else begin
         lead = SS3_LEAD;
      end
      if (lead == SS3_LEAD) trails = 2;
      send_byte(lead, 1'b0);
      if (trails == 2) send_byte(8'($urandom_range(255, 128)), 1'b0);
      send_byte(trail, 1'b0);
   endtask

   // Receiver: random ready, with one long hold-off on request
   initial begin : receiver
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            for (int i = 0; i < STALL_CYCLES; i++) begin
               rsp_ch.ready <= 1'b0;
               @(negedge clock);
            end
            stall_request = 1'b0;
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Compare every accepted result with the oldest expected byte
   always @(posedge clock) begin : result_check
      result_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected result: out_byte %h status %b run_last %b",
                   rsp_ch.out_byte, rsp_ch.status, rsp_ch.run_last);
            mismatch_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_ch.out_byte !== want.out_byte) begin
               $error("out_byte: expected %h, actual %h", want.out_byte, rsp_ch.out_byte);
               mismatch_count++;
            end
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %b, actual %b", want.status, rsp_ch.status);
               mismatch_count++;
            end
            if (rsp_ch.run_last !== want.run_last) begin
               $error("run_last: expected %b, actual %b", want.run_last, rsp_ch.run_last);
               mismatch_count++;
            end
         end
      end
   end

   // Stimulus
   initial begin : sender
      logic stall_done;
      logic pause_done;
      stall_done        = 1'b0;
      pause_done        = 1'b0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.data_byte  = 8'h00;
      req_ch.stream_end = 1'b0;
      frame_count       = 2'd0;
      frame_lead        = 8'h00;
      frame_second      = 8'h00;
      stream_halted     = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table: zero drop, bare end marker, extremes, every rewrite class
      add_row(8'h00, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      add_row(8'hff, 1'b1, 0, 8'h00, 8'h00, 8'h00);
      add_row(8'h01, 1'b0, 1, 8'h01, 8'h00, 8'h00);
      add_row(8'h7f, 1'b0, 1, 8'h7f, 8'h00, 8'h00);
      add_row(ROW_SYMBOL, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      add_row(CELL_MINUS, 1'b0, 1, ASCII_MINUS, 8'h00, 8'h00);
      add_row(ROW_SYMBOL, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      add_row(CELL_LPAREN, 1'b0, 1, ASCII_LPAREN, 8'h00, 8'h00);
      add_row(ROW_SYMBOL, 1'b0, UNTYPED, 8'h00, 8'h00, 8'h00);
      add_row(CELL_RPAREN, 1'b0, UNTYPED, 8'h00, 8'h00, 8'h00);
      add_row(ROW_ALNUM, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      add_row(DIGIT_FIRST, 1'b0, 1, ASCII_ZERO, 8'h00, 8'h00);
      add_row(ROW_ALNUM, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      add_row(UPPER_LAST, 1'b0, 1, 8'h5a, 8'h00, 8'h00);
      add_row(ROW_ALNUM, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      add_row(LOWER_LAST, 1'b0, 1, 8'h7a, 8'h00, 8'h00);
      // gap between upper and lower ranges passes through
      add_row(ROW_ALNUM, 1'b0, UNTYPED, 8'h00, 8'h00, 8'h00);
      add_row(8'he0, 1'b0, UNTYPED, 8'h00, 8'h00, 8'h00);
      // three-byte character is never rewritten
      add_row(SS3_LEAD, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      add_row(ROW_ALNUM, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      add_row(DIGIT_FIRST, 1'b0, 3, SS3_LEAD, ROW_ALNUM, DIGIT_FIRST);
      add_row(8'hff, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      add_row(8'hff, 1'b0, 2, 8'hff, 8'hff, 8'h00);
      add_row(8'h80, 1'b0, 0, 8'h00, 8'h00, 8'h00);
      add_row(8'h80, 1'b0, 2, 8'h80, 8'h80, 8'h00);
      foreach (dir_rows[i])
         offer_byte(dir_rows[i].data_in, dir_rows[i].end_in, dir_rows[i].typed,
                    dir_rows[i].count, dir_rows[i].bytes);

      // Random characters with a receiver hold-off, a drain pause and a calm stretch
      while (items_sent < RANDOM_ITEMS) begin
         send_random_char();
         if (!stall_done && items_sent >= 100) begin
            stall_request = 1'b1;
            stall_done    = 1'b1;
         end
         if (!pause_done && items_sent >= 200) begin
            req_ch.valid <= 1'b0;
            while (expected_bytes.size() != 0) @(posedge clock);
            @(negedge clock);
            pause_done = 1'b1;
         end
         if (items_sent >= 220 && items_sent < 280) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = 35;
            rsp_idle_pct = 35;
         end
      end

      // Malformed character halts the stream; everything after is dropped
      case ($urandom_range(3))
         0: begin
            send_byte(ROW_ALNUM, 1'b0);
            send_byte(8'($urandom_range(127, 1)), 1'b0);
         end
         1: begin
            send_byte(ROW_SYMBOL, 1'b0);
            send_byte(8'h00, 1'b0);
         end
         2: begin
            send_byte(SS3_LEAD, 1'b0);
            send_byte(ROW_SYMBOL, 1'b0);
            send_byte(8'($urandom_range(255)), 1'b1);
         end
         default: begin
            send_byte(SS3_LEAD, 1'b0);
            send_byte(8'($urandom_range(127)), 1'b0);
         end
      endcase
      repeat (6) send_random_char();
      req_ch.valid <= 1'b0;

      // Drain, then allow any stray result to show up
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
